FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the front, queue and back RTL files of the white balance block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define BWB_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// An implication checked at every clock edge outside reset.
`define BWB_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/bwb_pkg.sv
// ----------------------------------------------------------------------------
// bwb_pkg
// Types, constants and helpers shared by the Bayer white balance block.
// ----------------------------------------------------------------------------
package bwb_pkg;

  localparam int PixelW    = 16;
  localparam int GainW     = 8;
  localparam int OrderW    = 2;
  localparam int FracBits  = 6;
  localparam int ProdW     = PixelW + GainW;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 8;
  localparam int QueueDepthDefault = 4;

  localparam logic [GainW-1:0]  GainUnity = 8'd64;
  localparam logic [OrderW-1:0] OrderBggr = 2'd0;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BAYER_ORDER         = 3'd0,
    REG_GAIN_RED            = 3'd1,
    REG_GAIN_GREEN_RED_ROW  = 3'd2,
    REG_GAIN_BLUE           = 3'd3,
    REG_GAIN_GREEN_BLUE_ROW = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    SITE_RED         = 2'd0,
    SITE_GREEN_RED   = 2'd1,
    SITE_GREEN_BLUE  = 2'd2,
    SITE_BLUE        = 2'd3
  } site_e;

  typedef struct packed {
    logic [PixelW-1:0] pixel_in;
    logic              frame_start;
    logic              line_end;
  } in_item_t;

  typedef struct packed {
    logic [PixelW-1:0] pixel_out;
    logic              line_end_out;
  } out_item_t;

  typedef struct packed {
    logic [PixelW-1:0] pixel;
    logic [GainW-1:0]  gain;
    logic              line_end;
  } q_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // The four filter orders are the four XOR masks of the red site position.
  function automatic site_e site_of(input logic row_odd, input logic col_odd,
                                    input logic [OrderW-1:0] order);
    logic [1:0] pos;
    begin
      pos = {row_odd, col_odd};
      site_of = site_e'(pos ^ ~order);
    end
  endfunction

endpackage

FILE: rtl/bwb_front.sv
// ----------------------------------------------------------------------------
// bwb_front
// Holds the configuration, tracks row and column parity and tags each
// accepted item with the gain for its Bayer site.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bwb_front import bwb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                push_i,
  input  in_item_t            in_item_i,
  input  logic                q_full_i,
  output logic                q_wr_o,
  output q_item_t             q_item_o
);

  logic [OrderW-1:0] order_q;
  logic [GainW-1:0]  gain_r_q, gain_gr_q, gain_b_q, gain_gb_q;
  logic              row_odd_q, row_odd_d;
  logic              col_odd_q, col_odd_d;
  logic              row_cur, col_cur;
  logic              accept;
  logic [GainW-1:0]  gain_sel;

  assign accept = push_i & ~q_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q   <= OrderBggr;
      gain_r_q  <= GainUnity;
      gain_gr_q <= GainUnity;
      gain_b_q  <= GainUnity;
      gain_gb_q <= GainUnity;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BAYER_ORDER:         order_q   <= cfg_data_i[OrderW-1:0];
        REG_GAIN_RED:            gain_r_q  <= cfg_data_i[GainW-1:0];
        REG_GAIN_GREEN_RED_ROW:  gain_gr_q <= cfg_data_i[GainW-1:0];
        REG_GAIN_BLUE:           gain_b_q  <= cfg_data_i[GainW-1:0];
        REG_GAIN_GREEN_BLUE_ROW: gain_gb_q <= cfg_data_i[GainW-1:0];
        default: ;
      endcase
    end
  end

  // A frame start forces the item to row zero, column zero.
  always_comb begin
    row_cur = in_item_i.frame_start ? 1'b0 : row_odd_q;
    col_cur = in_item_i.frame_start ? 1'b0 : col_odd_q;
    if (in_item_i.line_end) begin
      row_odd_d = ~row_cur;
      col_odd_d = 1'b0;
    end else begin
      row_odd_d = row_cur;
      col_odd_d = ~col_cur;
    end
  end

  always_comb begin
    case (site_of(row_cur, col_cur, order_q))
      SITE_RED:        gain_sel = gain_r_q;
      SITE_GREEN_RED:  gain_sel = gain_gr_q;
      SITE_GREEN_BLUE: gain_sel = gain_gb_q;
      SITE_BLUE:       gain_sel = gain_b_q;
      default:         gain_sel = gain_b_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_odd_q <= 1'b0;
      col_odd_q <= 1'b0;
    end else if (accept) begin
      row_odd_q <= row_odd_d;
      col_odd_q <= col_odd_d;
    end
  end

  assign q_wr_o            = accept;
  assign q_item_o.pixel    = in_item_i.pixel_in;
  assign q_item_o.gain     = gain_sel;
  assign q_item_o.line_end = in_item_i.line_end;

  `BWB_ASSERT_IMP(a_line_end_resets_col, clk_i, rst_ni,
                  accept && in_item_i.line_end, !col_odd_q,
                  "column parity not cleared after a line end")

endmodule

FILE: rtl/bwb_queue.sv
// ----------------------------------------------------------------------------
// bwb_queue
// Short first-in first-out queue between the classifying front and the
// multiplying back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bwb_queue import bwb_pkg::*; #(
  parameter int Depth = QueueDepthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      wr_i,
  input  q_item_t   wr_item_i,
  input  logic      rd_i,
  output q_item_t   rd_item_o,
  output q_status_t status_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  q_item_t         mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_wr, do_rd;

  assign status_o.full  = (cnt_q == FullCnt);
  assign status_o.empty = (cnt_q == '0);
  assign do_wr = wr_i & ~status_o.full;
  assign do_rd = rd_i & ~status_o.empty;
  assign rd_item_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  `BWB_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= FullCnt,
              "queue fill count beyond depth")

endmodule

FILE: rtl/bwb_back.sv
// ----------------------------------------------------------------------------
// bwb_back
// Multiplies each queued pixel by its gain, scales and saturates it, and
// holds the result in the output register until it is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bwb_back import bwb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  q_status_t q_status_i,
  input  q_item_t   q_item_i,
  output logic      q_rd_o,
  input  logic      pop_i,
  output logic      empty_o,
  output out_item_t out_item_o
);

  logic [ProdW-1:0]  prod_q;
  logic              le1_q;
  logic              v1_q;
  out_item_t         out_q;
  logic              vo_q;
  logic              out_ready, s1_ready;
  logic [PixelW-1:0] scaled;

  assign out_ready = ~vo_q | pop_i;
  assign s1_ready  = ~v1_q | out_ready;
  assign q_rd_o    = ~q_status_i.empty & s1_ready;

  // Anything above the top 16 bits of the shifted product saturates.
  assign scaled = (|prod_q[ProdW-1:PixelW+FracBits]) ? {PixelW{1'b1}}
                                                     : prod_q[PixelW+FracBits-1:FracBits];

  always_ff @(posedge clk_i) begin
    if (q_rd_o) begin
      prod_q <= ProdW'(q_item_i.pixel) * ProdW'(q_item_i.gain);
      le1_q  <= q_item_i.line_end;
    end
    if (v1_q && out_ready) begin
      out_q.pixel_out    <= scaled;
      out_q.line_end_out <= le1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        v1_q <= q_rd_o;
      end
      if (out_ready) begin
        vo_q <= v1_q;
      end
    end
  end

  assign empty_o    = ~vo_q;
  assign out_item_o = out_q;

  `BWB_ASSERT_IMP(a_stage_holds, clk_i, rst_ni, v1_q && !out_ready,
                  v1_q && $stable(prod_q),
                  "product stage lost its item during a stall")

endmodule

FILE: rtl/bayer_white_balance_16bit.sv
// ----------------------------------------------------------------------------
// bayer_white_balance_16bit
// White balance gain for a raster stream of 16-bit Bayer raw pixels.
// ----------------------------------------------------------------------------
// Input channel: drive an item on in_item_i with push high; it is taken at
// a clock edge where full is low. frame_start marks row zero, column zero;
// line_end closes a line. Result channel: while empty is low, out_item_o
// holds the oldest result, taken at an edge where pop is high.
// Each result is (pixel * gain) >> 6, saturated to 65535, where the gain is
// chosen from the four 2.6 gains by row/column parity and the Bayer order.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 order, 1 red, 2 green on red rows, 3 blue, 4 green on blue rows).
// A result passes the queue memory, the multiply register and the output
// register. Throughput: one item per cycle, with pop high, set by the single
// 16x8 multiplier stage. When pop stays low the output register and product
// stage hold, the queue fills, and full rises once QueueDepth items wait in
// the queue.
// Reset clears the parity, the queue and the pipeline; the order returns to
// BGGR and every gain to unity (64).
// ----------------------------------------------------------------------------
module bayer_white_balance_16bit import bwb_pkg::*; #(
  parameter int QueueDepth = QueueDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                push,
  output logic                full,
  input  in_item_t            in_item_i,
  output logic                empty,
  input  logic                pop,
  output out_item_t           out_item_o
);

  logic      q_wr, q_rd;
  q_item_t   q_wr_item, q_rd_item;
  q_status_t q_status;

  assign full = q_status.full;

  bwb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .push_i     (push),
    .in_item_i  (in_item_i),
    .q_full_i   (q_status.full),
    .q_wr_o     (q_wr),
    .q_item_o   (q_wr_item)
  );

  bwb_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (q_wr),
    .wr_item_i (q_wr_item),
    .rd_i      (q_rd),
    .rd_item_o (q_rd_item),
    .status_o  (q_status)
  );

  bwb_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_status_i (q_status),
    .q_item_i   (q_rd_item),
    .q_rd_o     (q_rd),
    .pop_i      (pop),
    .empty_o    (empty),
    .out_item_o (out_item_o)
  );

endmodule

FILE: tb/bayer_white_balance_16bit_test.sv
// ----------------------------------------------------------------------------
// bayer_white_balance_16bit_test
// Self-checking bench for the Bayer white balance block.
// A scoreboard tracks row and column parity and the gain registers, predicts
// each gained and saturated pixel, and checks every popped result in order.
// Directed items come first, then random frames under several gain settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bayer_white_balance_16bit_test;
  import bwb_pkg::*;

  localparam int NumPhases      = 8;
  localparam int ItemsPerPhase  = 125;
  localparam int PipeLatency    = 4;
  localparam int LongHoldCycles = 80;
  localparam int WatchdogLimit  = 1000;
  // Index past the last register; writes to it must be ignored.
  localparam logic [CfgIdxW-1:0] UnusedRegIdx = 3'd5;

  class wb_scoreboard;
    logic [OrderW-1:0] order;
    logic [GainW-1:0]  gain_r, gain_grr, gain_b, gain_gbr;
    logic              col_odd, row_odd;
    out_item_t         expected_q[$];
    int n_items, n_frames, n_lines, n_saturated, n_errors;

    function new();
      order    = OrderBggr;
      gain_r   = GainUnity;
      gain_grr = GainUnity;
      gain_b   = GainUnity;
      gain_gbr = GainUnity;
      col_odd  = 1'b0;
      row_odd  = 1'b0;
    endfunction

    function void set_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
      case (idx)
        REG_BAYER_ORDER:         order    = data[OrderW-1:0];
        REG_GAIN_RED:            gain_r   = data[GainW-1:0];
        REG_GAIN_GREEN_RED_ROW:  gain_grr = data[GainW-1:0];
        REG_GAIN_BLUE:           gain_b   = data[GainW-1:0];
        REG_GAIN_GREEN_BLUE_ROW: gain_gbr = data[GainW-1:0];
        default: ;
      endcase
    endfunction

    function logic [GainW-1:0] gain_at(input logic r, input logic c);
      site_e s;
      s = site_e'({r, c} ^ (2'd3 - order));
      case (s)
        SITE_RED:        return gain_r;
        SITE_GREEN_RED:  return gain_grr;
        SITE_GREEN_BLUE: return gain_gbr;
        default:         return gain_b;
      endcase
    endfunction

    function void note_input(input in_item_t it);
      logic [ProdW-1:0] prod;
      out_item_t        exp_item;
      if (it.frame_start) begin
        row_odd = 1'b0;
        col_odd = 1'b0;
        n_frames++;
      end
      prod = ProdW'(it.pixel_in) * ProdW'(gain_at(row_odd, col_odd));
      prod = prod >> FracBits;
      if ((prod >> PixelW) != 0) begin
        exp_item.pixel_out = '1;
        n_saturated++;
      end else begin
        exp_item.pixel_out = prod[PixelW-1:0];
      end
      exp_item.line_end_out = it.line_end;
      if (it.line_end) begin
        col_odd = 1'b0;
        row_odd = ~row_odd;
        n_lines++;
      end else begin
        col_odd = ~col_odd;
      end
      expected_q.push_back(exp_item);
      n_items++;
    endfunction

    function void check_result(input out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, pixel_out %h line_end_out %b", $time,
                 got.pixel_out, got.line_end_out);
        n_errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.pixel_out !== want.pixel_out) begin
        $display("%0t: pixel_out mismatch, expected %h, actual %h", $time,
                 want.pixel_out, got.pixel_out);
        n_errors++;
      end
      if (got.line_end_out !== want.line_end_out) begin
        $display("%0t: line_end_out mismatch, expected %b, actual %b", $time,
                 want.line_end_out, got.line_end_out);
        n_errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                push;
  logic                full;
  in_item_t            in_item_i;
  logic                empty;
  logic                pop;
  out_item_t           out_item_o;

  wb_scoreboard sb = new();
  bit calm;
  bit hold_req;
  int n_settings;
  int stall_cycles;

  bayer_white_balance_16bit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Both handshakes are sampled here, before any drive made at this edge lands.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        sb.note_input(in_item_i);
      end
      if (pop && !empty) begin
        sb.check_result(out_item_o);
      end
      if ((push && !full) || (pop && !empty)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= WatchdogLimit) begin
        $display("%0t: no item moved for %0d cycles", $time, WatchdogLimit);
        $display("bayer_white_balance_16bit test failed");
        $finish;
      end
    end
  end

  // Result side: short random stalls, or one long hold when requested.
  initial begin
    int hold_left;
    hold_left = 0;
    pop <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LongHoldCycles;
      end
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        hold_left = $urandom_range(0, 2);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic send_item(input in_item_t it);
    push      <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  task automatic send_pixel(input logic [PixelW-1:0] pix, input logic fs, input logic le);
    in_item_t it;
    it.pixel_in    = pix;
    it.frame_start = fs;
    it.line_end    = le;
    send_item(it);
    if (!calm && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  // Stop offering items and wait until every expected result has been popped.
  task automatic drain_pipeline();
    push <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (PipeLatency) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
  endtask

  task automatic apply_setting(input logic [OrderW-1:0] order, input logic [GainW-1:0] g_r,
                               input logic [GainW-1:0] g_grr, input logic [GainW-1:0] g_b,
                               input logic [GainW-1:0] g_gbr);
    logic [CfgDataW-1:0] order_word;
    drain_pipeline();
    // The upper bits of the order word are junk and must not matter.
    order_word = CfgDataW'($urandom);
    order_word[OrderW-1:0] = order;
    write_reg(REG_BAYER_ORDER, order_word);
    write_reg(REG_GAIN_RED, g_r);
    write_reg(REG_GAIN_GREEN_RED_ROW, g_grr);
    write_reg(REG_GAIN_BLUE, g_b);
    write_reg(REG_GAIN_GREEN_BLUE_ROW, g_gbr);
    write_reg(UnusedRegIdx, CfgDataW'($urandom));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    n_settings++;
  endtask

  function automatic logic [PixelW-1:0] pick_pixel();
    case ($urandom_range(0, 7))
      0:       return '1;
      1:       return '0;
      default: return PixelW'($urandom);
    endcase
  endfunction

  task automatic run_phase(input int ph);
    logic [GainW-1:0] g [4];
    int  sent, width, height, n;
    bit  paused;
    for (int i = 0; i < 4; i++) begin
      case (ph)
        0:       g[i] = '0;
        1:       g[i] = '1;
        2:       g[i] = GainUnity;
        default: g[i] = GainW'($urandom);
      endcase
    end
    apply_setting(OrderW'(ph % 4), g[0], g[1], g[2], g[3]);
    // Last phase and one middle phase run with no idling on either side.
    calm = (ph == 5) || (ph == NumPhases - 1);
    if (ph == 3) hold_req = 1'b1;
    sent   = 0;
    paused = 1'b0;
    while (sent < ItemsPerPhase) begin
      if (ph == 4 && !paused && sent >= ItemsPerPhase / 2) begin
        drain_pipeline();
        paused = 1'b1;
      end
      if ($urandom_range(0, 6) != 0) begin
        width  = $urandom_range(1, 9);
        height = $urandom_range(1, 4);
        for (int r = 0; r < height; r++) begin
          for (int c = 0; c < width; c++) begin
            send_pixel(pick_pixel(), r == 0 && c == 0, c == width - 1);
            sent++;
          end
        end
      end else begin
        // Loose marks: stray frame starts and lines with no frame start.
        n = $urandom_range(1, 6);
        repeat (n) begin
          send_pixel(pick_pixel(), $urandom_range(0, 9) == 0, $urandom_range(0, 3) == 0);
          sent++;
        end
      end
    end
  endtask

  initial begin
    rst_ni     <= 1'b0;
    push       <= 1'b0;
    in_item_i  <= '0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= '0;
    cfg_data_i <= '0;
    calm       = 1'b1;
    hold_req   = 1'b0;
    n_settings = 0;
    stall_cycles = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: BGGR with unity gains passes pixels through.
    send_pixel(16'hFFFF, 1'b1, 1'b0);
    send_pixel(16'h0000, 1'b0, 1'b0);
    send_pixel(16'h1234, 1'b0, 1'b1);
    send_pixel(16'hABCD, 1'b0, 1'b0);
    send_pixel(16'h8001, 1'b0, 1'b1);

    // Saturation, zero gain, and a line that continues without a frame start.
    apply_setting(2'd0, 8'd255, 8'd0, 8'd128, 8'd1);
    send_pixel(16'hFFFF, 1'b1, 1'b0);
    send_pixel(16'hFFFF, 1'b0, 1'b1);
    send_pixel(16'hFFFF, 1'b0, 1'b0);
    send_pixel(16'hFFFF, 1'b0, 1'b1);
    send_pixel(16'hFFFF, 1'b0, 1'b1);

    // Frame start in the middle of a line, and one on a line end.
    apply_setting(2'd3, 8'd32, 8'd100, 8'd200, 8'd64);
    send_pixel(16'h4000, 1'b0, 1'b0);
    send_pixel(16'hFFFF, 1'b1, 1'b0);
    send_pixel(16'h7FFF, 1'b0, 1'b1);
    send_pixel(16'hC000, 1'b1, 1'b1);

    apply_setting(2'd1, 8'd255, 8'd255, 8'd255, 8'd255);
    send_pixel(16'hFFFF, 1'b1, 1'b0);
    send_pixel(16'h0001, 1'b0, 1'b1);
    send_pixel(16'h8000, 1'b0, 1'b0);
    send_pixel(16'h00FF, 1'b0, 1'b1);

    apply_setting(2'd2, 8'd0, 8'd64, 8'd128, 8'd192);
    send_pixel(16'hFFFF, 1'b1, 1'b0);
    send_pixel(16'hFFFF, 1'b0, 1'b1);
    send_pixel(16'hFFFF, 1'b0, 1'b0);
    send_pixel(16'hFFFF, 1'b0, 1'b1);

    for (int ph = 0; ph < NumPhases; ph++) begin
      run_phase(ph);
    end

    drain_pipeline();
    repeat (10) @(posedge clk_i);
    $display("Covered %0d pixels in %0d frames and %0d lines, %0d of them saturated.",
             sb.n_items, sb.n_frames, sb.n_lines, sb.n_saturated);
    $display("Used %0d register settings over all four filter orders, with stalls.",
             n_settings);
    if (sb.n_errors == 0) begin
      $display("bayer_white_balance_16bit test passed");
    end else begin
      $display("bayer_white_balance_16bit test failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/bwb_pkg.sv
rtl/bwb_front.sv
rtl/bwb_queue.sv
rtl/bwb_back.sv
rtl/bayer_white_balance_16bit.sv
tb/bayer_white_balance_16bit_test.sv
